@@ hw/rtl/mmip_pkg.sv @@
package mmip_pkg;

    localparam int CH_W        = 8;
    localparam int NUM_CH      = 3;
    localparam int SUM_W       = 10;
    localparam int CFG_W       = 13;
    localparam int DEPTH_LIMIT = 4096;
    localparam int SLICE_W     = 12;
    localparam int OUTQ_DEPTH  = 3;
    localparam int OUTQ_CNT_W  = 2;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chans;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        t_chans           chan;
    } t_entry;

    typedef struct packed {
        logic             take;
        logic [SUM_W-1:0] sum;
    } t_merge;

    typedef struct packed {
        t_chans chan;
        logic   frame_end;
    } t_result;

    // Last position for a dimension register: 0 counts as 1, above hi counts as hi.
    function automatic logic [CFG_W-1:0] f_last(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W:0] hi);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if ({1'b0, v} > hi) begin
            res = CFG_W'(hi - (CFG_W+1)'(1));
        end else begin
            res = v - CFG_W'(1);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/mmip_if.sv @@
interface mmip_in_if;
    logic                     valid;
    logic                     ready;
    logic [mmip_pkg::CH_W-1:0] chan_red;
    logic [mmip_pkg::CH_W-1:0] chan_green;
    logic [mmip_pkg::CH_W-1:0] chan_blue;

    modport source (output valid, output chan_red, output chan_green, output chan_blue,
                    input ready);
    modport sink (input valid, input chan_red, input chan_green, input chan_blue,
                  output ready);
endinterface

interface mmip_out_if;
    logic                     valid;
    logic                     ready;
    logic [mmip_pkg::CH_W-1:0] proj_red;
    logic [mmip_pkg::CH_W-1:0] proj_green;
    logic [mmip_pkg::CH_W-1:0] proj_blue;
    logic                     frame_end;

    modport source (output valid, output proj_red, output proj_green, output proj_blue,
                    output frame_end, input ready);
    modport sink (input valid, input proj_red, input proj_green, input proj_blue,
                  input frame_end, output ready);
endinterface

@@ hw/rtl/mmip_lane.sv @@
module mmip_lane #(
    parameter bit LANE_ON = 1'b1
) (
    input  logic [mmip_pkg::CH_W-1:0] i_chan,
    input  logic [mmip_pkg::CH_W-1:0] i_old_chan,
    input  logic                      i_take,
    output logic [mmip_pkg::CH_W-1:0] o_masked,
    output logic [mmip_pkg::CH_W-1:0] o_new_chan
);
    import mmip_pkg::*;

    // channels beyond the configured count read as zero
    assign o_masked   = LANE_ON ? i_chan : '0;
    assign o_new_chan = i_take ? o_masked : i_old_chan;

endmodule

@@ hw/rtl/mmip_merge.sv @@
module mmip_merge (
    input  mmip_pkg::t_chans                i_chan,
    input  logic [mmip_pkg::SUM_W-1:0]      i_old_sum,
    input  logic                            i_first,
    output mmip_pkg::t_merge                o_res
);
    import mmip_pkg::*;

    logic [SUM_W-1:0] sum;

    always_comb begin
        sum = '0;
        for (int k = 0; k < NUM_CH; k++) begin
            sum = sum + SUM_W'(i_chan[k]);
        end
    end

    // strictly greater wins, so the earliest slice keeps a tie
    assign o_res.sum  = sum;
    assign o_res.take = i_first || (sum > i_old_sum);

endmodule

@@ hw/rtl/mmip_store.sv @@
module mmip_store #(
    parameter int AW = 20,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ hw/rtl/mmip_outq.sv @@
module mmip_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  mmip_pkg::t_result               i_data,
    input  logic                            i_pop,
    output logic                            o_valid,
    output mmip_pkg::t_result               o_data,
    output logic [mmip_pkg::OUTQ_CNT_W-1:0] o_count
);
    import mmip_pkg::*;

    t_result                 r_slot [OUTQ_DEPTH];
    logic [OUTQ_CNT_W-1:0]   r_wr, n_wr;
    logic [OUTQ_CNT_W-1:0]   r_rd, n_rd;
    logic [OUTQ_CNT_W-1:0]   r_count, n_count;
    logic                    pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd];
    assign o_count = r_count;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == OUTQ_CNT_W'(OUTQ_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == OUTQ_CNT_W'(OUTQ_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < OUTQ_CNT_W'(OUTQ_DEPTH)) || pop_ok)
        else $error("output queue overflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("output queue count lost a transfer");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr == r_rd))
        else $error("output queue pointers out of step");

endmodule

@@ hw/rtl/multichannel_max_intensity_projection.sv @@
// Results: a voxel is registered in the update stage, and a last-slice result is pushed
//   from there into the output queue, which drives o_proj.
// Throughput: one voxel per cycle unless stalled; the frame store does one read and one
//   write per cycle, 1-entry forward. i_vox stalls at three queued or in-flight results.
// Reset (i_rst_n, synchronous, active low): clears counters, pipeline and output queue;
//   width 1024, height 1024, depth 1. The frame store is not cleared.
module multichannel_max_intensity_projection #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int CHANNELS   = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mmip_in_if.sink                          i_vox,
    mmip_out_if.source                       o_proj,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmip_pkg::PADDR_W-1:0]     paddr,
    input  logic [mmip_pkg::PDATA_W-1:0]     pwdata,
    output logic [mmip_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready
);
    import mmip_pkg::*;

    localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
    localparam int EW  = $bits(t_entry);

    // ---------------------------------------------------------------- config
    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [12:0] r_depth;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
            r_depth  <= 13'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[10:0];
                REG_HEIGHT: r_height <= pwdata[10:0];
                REG_DEPTH:  r_depth  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = PDATA_W'(r_width);
            REG_HEIGHT: prdata = PDATA_W'(r_height);
            REG_DEPTH:  prdata = PDATA_W'(r_depth);
            default:    prdata = '0;
        endcase
    end

    // saturated last positions
    logic [CFG_W-1:0] w_last13, h_last13, d_last13;
    logic [CW-1:0]    col_last;
    logic [RW-1:0]    row_last;
    logic [SLICE_W-1:0] slice_last;

    assign w_last13   = f_last(CFG_W'(r_width),  (CFG_W+1)'(MAX_WIDTH));
    assign h_last13   = f_last(CFG_W'(r_height), (CFG_W+1)'(MAX_HEIGHT));
    assign d_last13   = f_last(r_depth,          (CFG_W+1)'(DEPTH_LIMIT));
    assign col_last   = w_last13[CW-1:0];
    assign row_last   = h_last13[RW-1:0];
    assign slice_last = d_last13[SLICE_W-1:0];

    // ------------------------------------------------------ raster position
    logic [CW-1:0]      r_col;
    logic [RW-1:0]      r_row;
    logic [SLICE_W-1:0] r_slice;
    logic               last_col, last_row, last_slice;
    logic [CW-1:0]      col_sel;
    logic [RW-1:0]      row_sel;
    logic [AW-1:0]      n_addr;
    logic               acc;

    // a counter left beyond a shrunk dimension is taken as its last position
    assign last_col   = (r_col   >= col_last);
    assign last_row   = (r_row   >= row_last);
    assign last_slice = (r_slice >= slice_last);
    assign col_sel    = last_col ? col_last : r_col;
    assign row_sel    = last_row ? row_last : r_row;
    assign n_addr     = AW'(AW'(row_sel) * AW'(MAX_WIDTH)) + AW'(col_sel);

    assign acc = i_vox.valid && i_vox.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else if (acc) begin
            if (!last_col) begin
                r_col <= col_sel + 1'b1;
            end else begin
                r_col <= '0;
                if (!last_row) begin
                    r_row <= row_sel + 1'b1;
                end else begin
                    r_row   <= '0;
                    r_slice <= last_slice ? '0 : r_slice + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------- compare-and-update stage
    logic               r_s1_valid;
    logic               r_s1_emit;
    logic               r_s1_first;
    logic               r_s1_fend;
    logic               r_s1_hit;
    logic [AW-1:0]      r_s1_addr;
    t_chans             r_s1_chan;
    t_entry             r_fwd;
    logic [EW-1:0]      mem_rdata;
    t_entry             old_entry;
    t_entry             new_entry;
    t_chans             masked;
    t_merge             mres;
    logic [OUTQ_CNT_W-1:0] q_count;
    logic [OUTQ_CNT_W:0]   q_load;
    t_result            q_in;
    t_result            q_out;
    logic               q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_hit   <= 1'b0;
        end else begin
            r_s1_valid <= acc;
            // previous item writes on the same edge that this one reads
            r_s1_hit   <= acc && r_s1_valid && (r_s1_addr == n_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr  <= n_addr;
            r_s1_chan  <= {i_vox.chan_blue, i_vox.chan_green, i_vox.chan_red};
            r_s1_emit  <= last_slice;
            r_s1_first <= (r_slice == '0);
            r_s1_fend  <= last_col && last_row;
        end
        if (r_s1_valid) begin
            r_fwd <= new_entry;
        end
    end

    mmip_store #(
        .AW (AW),
        .DW (EW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (new_entry),
        .i_raddr (n_addr),
        .o_rdata (mem_rdata)
    );

    assign old_entry = r_s1_hit ? r_fwd : t_entry'(mem_rdata);

    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        mmip_lane #(
            .LANE_ON (g < CHANNELS)
        ) u_lane (
            .i_chan     (r_s1_chan[g]),
            .i_old_chan (old_entry.chan[g]),
            .i_take     (mres.take),
            .o_masked   (masked[g]),
            .o_new_chan (new_entry.chan[g])
        );
    end

    mmip_merge u_merge (
        .i_chan    (masked),
        .i_old_sum (old_entry.sum),
        .i_first   (r_s1_first),
        .o_res     (mres)
    );

    assign new_entry.sum = mres.take ? mres.sum : old_entry.sum;

    // ------------------------------------------------------- output queue
    assign q_in.chan      = new_entry.chan;
    assign q_in.frame_end = r_s1_fend;

    mmip_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid && r_s1_emit),
        .i_data  (q_in),
        .i_pop   (o_proj.ready),
        .o_valid (q_valid),
        .o_data  (q_out),
        .o_count (q_count)
    );

    // room for the item in flight plus the one about to be taken
    assign q_load      = (OUTQ_CNT_W+1)'(q_count) + (OUTQ_CNT_W+1)'(r_s1_valid && r_s1_emit);
    assign i_vox.ready = (q_load < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));

    assign o_proj.valid      = q_valid;
    assign o_proj.proj_red   = q_out.chan[0];
    assign o_proj.proj_green = q_out.chan[1];
    assign o_proj.proj_blue  = q_out.chan[2];
    assign o_proj.frame_end  = q_out.frame_end;

    // ---------------------------------------------------------- assertions
    a_hit_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_hit |-> r_s1_valid && $past(r_s1_valid))
        else $error("forward hit without a preceding write");

    a_emit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && last_slice) |=> (r_s1_valid && r_s1_emit))
        else $error("last-slice transfer did not reach the update stage");

    a_first_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_first) |-> mres.take)
        else $error("first slice did not load the frame store");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vox.ready |-> (q_load == (OUTQ_CNT_W+1)'(OUTQ_DEPTH)))
        else $error("input stalled with room in the output queue");

endmodule
